### design/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Opcodes, status codes and the controller-to-datapath command type for the
// circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int unsigned DataWidth   = 32;
    localparam int unsigned OpWidth     = 3;
    localparam int unsigned StatusWidth = 2;

    typedef logic [OpWidth-1:0]     t_opcode;
    typedef logic [StatusWidth-1:0] t_status;
    typedef logic [DataWidth-1:0]   t_word;

    localparam t_opcode OP_PUSH_BACK  = 3'd0;
    localparam t_opcode OP_PUSH_FRONT = 3'd1;
    localparam t_opcode OP_POP_FRONT  = 3'd2;
    localparam t_opcode OP_POP_BACK   = 3'd3;
    localparam t_opcode OP_PEEK_FRONT = 3'd4;
    localparam t_opcode OP_PEEK_BACK  = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the accepted request
        logic exec;   // perform the slot access and pointer update
    } t_dp_cmd;

endpackage

### design/circular_deque_core.sv
// ----------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue of signed 32-bit words in a ring of DEPTH slots, holding
// at most DEPTH-1 words. Push, pop and peek at either end; one result each.
// ----------------------------------------------------------------------------
//
//  channel  handshake                  fields
//  -------  -------------------------  ----------------------------------------
//  in       i_in_valid / o_in_stall    i_opcode, i_push_value
//  out      o_out_valid / i_out_stall  o_read_value, o_status, o_is_empty,
//                                      o_is_full
//
//  A request is captured at the accepting edge; the slot access on the
//  single-port memory runs in S_EXEC, and the result is then presented in S_OUT
//  until the output side takes it.
//  The next request is accepted the cycle after the result is taken, so a new
//  request is not taken before the last result has been taken.
//  A stall on the output holds the result and keeps o_in_stall high.
//  Reset (synchronous, active low) empties the deque: front at slot 0, back
//  at the last slot. The slot memory is not cleared; only written slots are
//  ever read.
// ----------------------------------------------------------------------------
module circular_deque_core #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [cdq_pkg::OpWidth-1:0]          i_opcode,
    input  logic signed [cdq_pkg::DataWidth-1:0] i_push_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [cdq_pkg::DataWidth-1:0] o_read_value,
    output logic [cdq_pkg::StatusWidth-1:0]      o_status,
    output logic                                 o_is_empty,
    output logic                                 o_is_full
);

    cdq_pkg::t_dp_cmd dp_cmd;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd)
    );

    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

    // An accepted request never produces a result in the very next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !o_out_valid)
        else $error("result presented one cycle after acceptance");

    // No new request while a result is pending
    a_stall_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_empty && o_is_full))
        else $error("deque flagged empty and full together");

    // A refused push leaves the deque full; a refused pop or peek leaves it empty
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == cdq_pkg::ST_FULL)) |-> o_is_full)
        else $error("full status without full flag");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == cdq_pkg::ST_EMPTY)) |->
            (o_is_empty && (o_read_value == '0)))
        else $error("empty status with data or without empty flag");

endmodule

### design/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer for the deque: accept a request, run one slot access, then hold
// the result until the output side takes it.
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output cdq_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

### design/cdq_dp.sv
// ----------------------------------------------------------------------------
// cdq_dp
// Deque datapath: slot memory, front and back pointers, result registers.
// ----------------------------------------------------------------------------
module cdq_dp #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cdq_pkg::t_dp_cmd               i_cmd,
    input  logic [cdq_pkg::OpWidth-1:0]    i_opcode,
    input  logic signed [cdq_pkg::DataWidth-1:0] i_push_value,
    output logic signed [cdq_pkg::DataWidth-1:0] o_read_value,
    output logic [cdq_pkg::StatusWidth-1:0] o_status,
    output logic                           o_is_empty,
    output logic                           o_is_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

    cdq_pkg::t_word   r_mem [DEPTH];

    cdq_pkg::t_opcode r_op;
    cdq_pkg::t_word   r_val;
    logic [AW-1:0]    r_front;
    logic [AW-1:0]    r_back;
    logic [AW-1:0]    n_front;
    logic [AW-1:0]    n_back;
    cdq_pkg::t_word   r_rd_data;
    logic             r_rd_ok;
    cdq_pkg::t_status r_status;
    cdq_pkg::t_status n_status;

    logic [AW-1:0]    back_next;
    logic [AW-1:0]    back_next2;
    logic [AW-1:0]    back_prev;
    logic [AW-1:0]    front_next;
    logic [AW-1:0]    front_prev;
    logic             dq_empty;
    logic             dq_full;
    logic             do_write;
    logic             do_read;
    logic [AW-1:0]    slot_addr;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        return (idx == LastSlot) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] idx);
        return (idx == '0) ? LastSlot : idx - AW'(1);
    endfunction

    assign back_next  = ring_next(r_back);
    assign back_next2 = ring_next(back_next);
    assign back_prev  = ring_prev(r_back);
    assign front_next = ring_next(r_front);
    assign front_prev = ring_prev(r_front);
    assign dq_empty   = (back_next == r_front);
    assign dq_full    = (back_next2 == r_front);

    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_status  = cdq_pkg::ST_OK;
        do_write  = 1'b0;
        do_read   = 1'b0;
        slot_addr = r_front;
        case (r_op) inside
            cdq_pkg::OP_PUSH_BACK, cdq_pkg::OP_PUSH_FRONT: begin
                if (dq_full) begin
                    n_status = cdq_pkg::ST_FULL;
                end else if (r_op == cdq_pkg::OP_PUSH_BACK) begin
                    do_write  = 1'b1;
                    slot_addr = back_next;
                    n_back    = back_next;
                end else begin
                    do_write  = 1'b1;
                    slot_addr = front_prev;
                    n_front   = front_prev;
                end
            end
            cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_PEEK_FRONT: begin
                if (dq_empty) begin
                    n_status = cdq_pkg::ST_EMPTY;
                end else begin
                    do_read   = 1'b1;
                    slot_addr = r_front;
                    if (r_op == cdq_pkg::OP_POP_FRONT) begin
                        n_front = front_next;
                    end
                end
            end
            cdq_pkg::OP_POP_BACK, cdq_pkg::OP_PEEK_BACK: begin
                if (dq_empty) begin
                    n_status = cdq_pkg::ST_EMPTY;
                end else begin
                    do_read   = 1'b1;
                    slot_addr = r_back;
                    if (r_op == cdq_pkg::OP_POP_BACK) begin
                        n_back = back_prev;
                    end
                end
            end
            default: begin
                // unused codes leave the deque alone
            end
        endcase
    end

    // Request capture; payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_val <= cdq_pkg::t_word'(i_push_value);
        end
    end

    // Single-port slot memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_write) begin
            r_mem[slot_addr] <= r_val;
        end
        if (i_cmd.exec && do_read) begin
            r_rd_data <= r_mem[slot_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_back   <= LastSlot;
            r_rd_ok  <= 1'b0;
            r_status <= cdq_pkg::ST_OK;
        end else if (i_cmd.exec) begin
            r_front  <= n_front;
            r_back   <= n_back;
            r_rd_ok  <= do_read;
            r_status <= n_status;
        end
    end

    // Pointers hold while the result waits, so the flags stay valid
    assign o_read_value = r_rd_ok ? $signed(r_rd_data) : '0;
    assign o_status     = r_status;
    assign o_is_empty   = dq_empty;
    assign o_is_full    = dq_full;

endmodule
